// ===== rtl/afr_pkg.sv =====
// Shared types and constants for the API frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

  localparam logic [7:0]  START_DELIM     = 8'h7E;
  localparam logic [7:0]  CSUM_BASE       = 8'hFF;
  localparam logic [15:0] SHORT_LEN_RESET = 16'd7;
  localparam logic [7:0]  HDR_SKIP_RESET  = 8'd18;

  typedef enum logic [1:0] {
    CFG_SHORT_LENGTH = 2'd0,
    CFG_HEADER_SKIP  = 2'd1
  } cfg_index_e;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_CSUM   = 3'd4
  } phase_e;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [15:0] data_index;
    logic        is_payload;
    logic        frame_end;
    logic        frame_good;
  } afr_result_t;

endpackage

`default_nettype wire

// ===== rtl/api_frame_receiver_top.sv =====
// Top level of the API frame receiver: deframer, checksum check and output buffer.
//
// Usage: feed received serial bytes on the input channel (in_valid_i, rx_byte_i,
// in_stall_o). Every accepted byte yields exactly one result beat on the output
// channel (out_valid_o, the result fields, out_stall_i). In the hunt phase the
// block waits for 0x7E, then takes a 16-bit length (high byte first), that many
// data bytes and one checksum byte. Data bytes come out with their index and a
// payload mark; the checksum byte comes out with frame_end and frame_good.
// Results are registered in the output register, or in the skid entry on a stall.
// Throughput: one byte per cycle while not stalled; frame state updates per byte.
// Stall: results go into a two-entry buffer (output register plus skid), so a
// byte is still taken in the cycle the receiver first stalls; in_stall_o rises
// only once both entries are full and falls as soon as the output drains.
// Reset: clears the buffer, returns to the hunt phase and loads the register
// defaults (short_length 7, header_skip 18). Register writes take effect on the
// next byte; the user must write only while the block is idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module api_frame_receiver_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  // output channel
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        data_valid_o,
  output      logic [7:0]  data_byte_o,
  output      logic [15:0] data_index_o,
  output      logic        is_payload_o,
  output      logic        frame_end_o,
  output      logic        frame_good_o
);

  logic [15:0] short_len_q;
  logic [7:0]  hdr_skip_q;

  afr_pkg::phase_e phase_q, phase_d;
  logic [15:0] frame_len_q, frame_len_d;
  logic [15:0] byte_cnt_q, byte_cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] byte_cnt_inc;

  afr_pkg::afr_result_t res_d;
  afr_pkg::afr_result_t main_q, skid_q;
  logic main_valid_q, skid_valid_q;
  logic in_acc, out_take;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_take   = main_valid_q & ~out_stall_i;

  assign data_valid_o = main_q.data_valid;
  assign data_byte_o  = main_q.data_byte;
  assign data_index_o = main_q.data_index;
  assign is_payload_o = main_q.is_payload;
  assign frame_end_o  = main_q.frame_end;
  assign frame_good_o = main_q.frame_good;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len_q <= afr_pkg::SHORT_LEN_RESET;
      hdr_skip_q  <= afr_pkg::HDR_SKIP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        afr_pkg::CFG_SHORT_LENGTH: short_len_q <= cfg_data_i;
        afr_pkg::CFG_HEADER_SKIP:  hdr_skip_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign byte_cnt_inc = byte_cnt_q + 16'd1;

  // frame state machine: next state and result for the byte at the input
  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    byte_cnt_d  = byte_cnt_q;
    sum_d       = sum_q;
    res_d       = '0;
    case (phase_q)
      afr_pkg::PH_HUNT: begin
        if (rx_byte_i == afr_pkg::START_DELIM) begin
          phase_d = afr_pkg::PH_LEN_HI;
        end
      end
      afr_pkg::PH_LEN_HI: begin
        frame_len_d = {rx_byte_i, 8'h00};
        phase_d     = afr_pkg::PH_LEN_LO;
      end
      afr_pkg::PH_LEN_LO: begin
        frame_len_d = {frame_len_q[15:8], rx_byte_i};
        byte_cnt_d  = '0;
        sum_d       = '0;
        // a zero-length frame goes straight to its checksum byte
        phase_d = (frame_len_d == 16'd0) ? afr_pkg::PH_CSUM : afr_pkg::PH_DATA;
      end
      afr_pkg::PH_DATA: begin
        res_d.data_valid = 1'b1;
        res_d.data_byte  = rx_byte_i;
        res_d.data_index = byte_cnt_q;
        res_d.is_payload = (frame_len_q == short_len_q) ||
                           (byte_cnt_q >= {8'h00, hdr_skip_q});
        sum_d      = sum_q + rx_byte_i;
        byte_cnt_d = byte_cnt_inc;
        if (byte_cnt_inc == frame_len_q) begin
          phase_d = afr_pkg::PH_CSUM;
        end
      end
      afr_pkg::PH_CSUM: begin
        res_d.frame_end  = 1'b1;
        res_d.frame_good = ((afr_pkg::CSUM_BASE - sum_q) == rx_byte_i);
        phase_d     = afr_pkg::PH_HUNT;
        frame_len_d = '0;
        byte_cnt_d  = '0;
        sum_d       = '0;
      end
      default: begin
        phase_d = afr_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= afr_pkg::PH_HUNT;
      frame_len_q <= '0;
      byte_cnt_q  <= '0;
      sum_q       <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      byte_cnt_q  <= byte_cnt_d;
      sum_q       <= sum_d;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      if (!main_valid_q || out_take) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      main_valid_q <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!main_valid_q || out_take) begin
        main_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end else if (out_take) begin
      main_q <= skid_q;
    end
  end

  // checks
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(main_valid_q && out_stall_i))
    else $error("skid entry filled without a stalled output");

  a_data_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == afr_pkg::PH_DATA) |-> (byte_cnt_q < frame_len_q))
    else $error("data byte count reached frame length in data phase");

  a_csum_returns_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == afr_pkg::PH_CSUM) |=> (phase_q == afr_pkg::PH_HUNT))
    else $error("checksum byte did not return to hunt");

  a_good_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_valid_q && main_q.frame_good) |-> (main_q.frame_end && !main_q.data_valid))
    else $error("frame_good without frame_end");

endmodule

`default_nettype wire
